### design/cbor_pkg.sv
// cbor_pkg: shared types and constants for the cbor head and float encoder
// no dependencies
package cbor_pkg;

  typedef struct packed {
    logic        command;
    logic [2:0]  major_type;
    logic [63:0] value;
  } cbor_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } cbor_out_t;

  // classified item: initial byte, big-endian payload left-aligned, payload length
  typedef struct packed {
    logic [7:0]  first;
    logic [63:0] payload;
    logic [3:0]  len;
  } cbor_job_t;

  localparam logic CMD_HEAD  = 1'b0;
  localparam logic CMD_FLOAT = 1'b1;

  localparam logic [4:0] AI_1 = 5'd24;
  localparam logic [4:0] AI_2 = 5'd25;
  localparam logic [4:0] AI_4 = 5'd26;
  localparam logic [4:0] AI_8 = 5'd27;

  localparam logic [7:0] IB_HALF   = 8'hf9;
  localparam logic [7:0] IB_SINGLE = 8'hfa;
  localparam logic [7:0] IB_DOUBLE = 8'hfb;

  localparam logic [15:0] HALF_NAN = 16'h7e00;
  localparam logic [15:0] HALF_INF = 16'h7c00;

  localparam int QDEPTH = 2;

endpackage

### design/cbor_front.sv
// cbor_front: classifies an accepted item into initial byte and payload run
// depends on cbor_pkg
module cbor_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  cbor_pkg::cbor_in_t item,
  output logic               job_vld,
  output cbor_pkg::cbor_job_t job
);
  import cbor_pkg::*;

  logic      job_vld_r;
  cbor_job_t job_r, job_nxt;

  logic        sgn;
  logic [10:0] bexp;
  logic [51:0] man;
  logic [52:0] full;
  logic signed [12:0] e;
  logic [5:0]  hsh, ssh;
  logic [52:0] hmask, smask;
  logic [2:0]  top;

  always_comb begin
    sgn  = item.value[63];
    bexp = item.value[62:52];
    man  = item.value[51:0];
    full = {1'b1, man};
    e    = $signed({2'b00, bexp}) - 13'sd1023;
    // shift amounts for subnormal half and single, truncated to six bits; only meaningful in their exponent ranges
    hsh   = 6'(28 - e);
    ssh   = 6'(-97 - e);
    hmask = (53'd1 << hsh) - 53'd1;
    smask = (53'd1 << ssh) - 53'd1;
    top   = item.major_type;
    job_nxt = '0;
    if (item.command == CMD_HEAD) begin
      if (item.value < 64'd24) begin
        job_nxt.first = {top, item.value[4:0]};
        job_nxt.len   = 4'd0;
      end else if (item.value[63:8] == '0) begin
        job_nxt.first = {top, AI_1};
        job_nxt.payload = {item.value[7:0], 56'd0};
        job_nxt.len   = 4'd1;
      end else if (item.value[63:16] == '0) begin
        job_nxt.first = {top, AI_2};
        job_nxt.payload = {item.value[15:0], 48'd0};
        job_nxt.len   = 4'd2;
      end else if (item.value[63:32] == '0) begin
        job_nxt.first = {top, AI_4};
        job_nxt.payload = {item.value[31:0], 32'd0};
        job_nxt.len   = 4'd4;
      end else begin
        job_nxt.first = {top, AI_8};
        job_nxt.payload = item.value;
        job_nxt.len   = 4'd8;
      end
    end else begin
      job_nxt.first   = IB_DOUBLE;
      job_nxt.payload = item.value;
      job_nxt.len     = 4'd8;
      if (bexp == 11'h7ff) begin
        job_nxt.first   = IB_HALF;
        job_nxt.payload = {{sgn, 15'd0} | ((man != '0) ? HALF_NAN : HALF_INF), 48'd0};
        job_nxt.len     = 4'd2;
      end else if (bexp == '0) begin
        if (man == '0) begin
          job_nxt.first   = IB_HALF;
          job_nxt.payload = {sgn, 63'd0};
          job_nxt.len     = 4'd2;
        end
      end else if (e >= -13'sd14 && e <= 13'sd15 && man[41:0] == '0) begin
        job_nxt.first   = IB_HALF;
        job_nxt.payload = {sgn, 5'(e + 13'sd15), man[51:42], 48'd0};
        job_nxt.len     = 4'd2;
      end else if (e >= -13'sd24 && e < -13'sd14 && (full & hmask) == '0) begin
        job_nxt.first   = IB_HALF;
        job_nxt.payload = {sgn, 15'(full >> hsh), 48'd0};
        job_nxt.len     = 4'd2;
      end else if (e >= -13'sd126 && e <= 13'sd127 && man[28:0] == '0) begin
        job_nxt.first   = IB_SINGLE;
        job_nxt.payload = {sgn, 8'(e + 13'sd127), man[51:29], 32'd0};
        job_nxt.len     = 4'd4;
      end else if (e >= -13'sd149 && e < -13'sd126 && (full & smask) == '0) begin
        job_nxt.first   = IB_SINGLE;
        job_nxt.payload = {sgn, 31'(full >> ssh), 32'd0};
        job_nxt.len     = 4'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else begin
      job_vld_r <= acc;
    end
    if (acc) begin
      job_r <= job_nxt;
    end
  end

  assign job_vld = job_vld_r;
  assign job     = job_r;

endmodule

### design/cbor_queue.sv
// cbor_queue: short fifo of classified jobs between front and back
// depends on cbor_pkg
module cbor_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  cbor_pkg::cbor_job_t wdata,
  input  logic                rd,
  output logic                not_empty,
  output logic [1:0]          count,
  output cbor_pkg::cbor_job_t rdata
);
  import cbor_pkg::*;

  cbor_job_t mem_r [QDEPTH];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign not_empty = cnt_r != '0;
  assign count     = cnt_r;
  assign rdata     = mem_r[rp_r];

endmodule

### design/cbor_back.sv
// cbor_back: serializes one job into bytes, one per cycle, marking the last
// depends on cbor_pkg
module cbor_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_rdy,
  input  cbor_pkg::cbor_job_t job,
  output logic                take,
  output logic                out_valid,
  output cbor_pkg::cbor_out_t out_data
);
  import cbor_pkg::*;

  logic        act_r;
  logic [63:0] sh_r;
  logic [3:0]  left_r;
  logic        ov_r;
  cbor_out_t   od_r;

  // a new job is taken once every payload byte of the previous one has left;
  // the initial byte goes out on the taking edge, so jobs still stream gap-free
  assign take = job_rdy && !act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
      left_r <= '0;
    end else begin
      ov_r <= take || act_r;
      if (take) begin
        act_r  <= job.len != 4'd0;
        left_r <= job.len;
      end else if (act_r) begin
        left_r <= left_r - 4'd1;
        act_r  <= left_r != 4'd1;
      end
    end
    if (take) begin
      od_r.out_byte <= job.first;
      od_r.last     <= job.len == 4'd0;
      sh_r          <= job.payload;
    end else if (act_r) begin
      od_r.out_byte <= sh_r[63:56];
      od_r.last     <= left_r == 4'd1;
      sh_r          <= {sh_r[55:0], 8'd0};
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

### design/cbor_head_and_float_encoder.sv
// cbor_head_and_float_encoder: top level, front classifier, job queue, byte serializer
// depends on cbor_pkg, cbor_front, cbor_queue, cbor_back
//
//  channel | ports                          | transaction
//  input   | in_start, in_busy, in_data     | start && !busy at a rising edge
//  result  | out_valid, out_data            | every cycle out_valid is high
//
// one byte leaves per cycle while an item is being sent; an item is 1 to 9 bytes long,
// its encoded length, and is sent by the byte serializer in the back part
// classification is registered in the front register, then the job passes through
// the queue to the serializer's output register; back-to-back items stream without a gap
// synchronous active-low reset clears queue, valid flags and counters
// busy rises when the job queue and the front register could overflow
module cbor_head_and_float_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  output logic                in_busy,
  input  cbor_pkg::cbor_in_t  in_data,
  output logic                out_valid,
  output cbor_pkg::cbor_out_t out_data
);
  import cbor_pkg::*;

  logic      acc;
  logic      f_vld;
  cbor_job_t f_job;
  logic      q_ne, q_rd;
  logic [1:0] q_cnt;
  cbor_job_t q_job;

  // transaction accepted on the input side
  assign acc = in_start && !in_busy;
  // hold off while front register plus queue would exceed queue depth
  assign in_busy = (2'(q_cnt) + 2'(f_vld)) >= 2'(QDEPTH) && !q_rd;

  cbor_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .item(in_data),
    .job_vld(f_vld), .job(f_job)
  );

  cbor_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(f_vld), .wdata(f_job),
    .rd(q_rd), .not_empty(q_ne), .count(q_cnt), .rdata(q_job)
  );

  cbor_back u_back (
    .clk(clk), .rst_n(rst_n), .job_rdy(q_ne), .job(q_job), .take(q_rd),
    .out_valid(out_valid), .out_data(out_data)
  );

`ifndef SYNTH
  // queue never overflows
  assert property (@(posedge clk) disable iff (!rst_n)
    !(f_vld && q_cnt == 2'(QDEPTH) && !q_rd))
    else $error("job queue overflow");
  // an accepted item reaches the front register next cycle
  assert property (@(posedge clk) disable iff (!rst_n) acc |=> f_vld)
    else $error("front lost an item");
  // a short item always ends on its first byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_rd && q_job.len == 4'd0) |=> (out_valid && out_data.last))
    else $error("single byte item not marked last");
`endif

endmodule

### tb/cbor_checker.sv
// cbor_checker: predicts the byte stream of each accepted transaction and compares it
// depends on cbor_pkg; watches the input and result channels of the encoder
module cbor_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  logic                in_busy,
  input  cbor_pkg::cbor_in_t  in_data,
  input  logic                out_valid,
  input  cbor_pkg::cbor_out_t out_data,
  output int                  fail_count,
  output int                  pending_bytes
);
  import cbor_pkg::*;

  cbor_out_t byte_q[$];

  // append first byte plus len big-endian payload bytes, marking the final one
  function automatic void push_be(logic [7:0] first, logic [63:0] payload, int len);
    cbor_out_t b;
    b.out_byte = first;
    b.last = (len == 0);
    byte_q.push_back(b);
    for (int k = 0; k < len; k++) begin
      b.out_byte = payload[8*(len-1-k) +: 8];
      b.last = (k == len - 1);
      byte_q.push_back(b);
    end
  endfunction

  function automatic void encode_head(logic [2:0] mt, logic [63:0] arg);
    logic [7:0] top;
    top = {mt, 5'd0};
    if (arg < 24) push_be(top | arg[7:0], '0, 0);
    else if (arg <= 64'hff) push_be(top | AI_1, arg, 1);
    else if (arg <= 64'hffff) push_be(top | AI_2, arg, 2);
    else if (arg <= 64'hffff_ffff) push_be(top | AI_4, arg, 4);
    else push_be(top | AI_8, arg, 8);
  endfunction

  function automatic void encode_float(logic [63:0] bits);
    logic        sgn;
    logic [10:0] bexp;
    logic [51:0] man;
    logic [52:0] full;
    logic [15:0] h16;
    logic [31:0] s32;
    int          e;
    sgn = bits[63];
    bexp = bits[62:52];
    man = bits[51:0];
    full = {1'b1, man};
    h16 = {sgn, 15'd0};
    s32 = {sgn, 31'd0};
    e = int'(bexp) - 1023;
    if (bexp == 11'h7ff) begin
      h16 |= (man != 0) ? HALF_NAN : HALF_INF;
      push_be(IB_HALF, h16, 2);
    end else if (bexp == 0) begin
      if (man == 0) push_be(IB_HALF, h16, 2);
      else push_be(IB_DOUBLE, bits, 8);
    end else if (e >= -14 && e <= 15 && man[41:0] == 0) begin
      h16 |= {1'b0, 5'(e + 15), man[51:42]};
      push_be(IB_HALF, h16, 2);
    end else if (e >= -24 && e < -14 && (full & ((53'd1 << (28 - e)) - 1)) == 0) begin
      h16 |= 16'(full >> (28 - e));
      push_be(IB_HALF, h16, 2);
    end else if (e >= -126 && e <= 127 && man[28:0] == 0) begin
      s32 |= {1'b0, 8'(e + 127), man[51:29]};
      push_be(IB_SINGLE, s32, 4);
    end else if (e >= -149 && e < -126 && (full & ((53'd1 << (-97 - e)) - 1)) == 0) begin
      s32 |= 32'(full >> (-97 - e));
      push_be(IB_SINGLE, s32, 4);
    end else begin
      push_be(IB_DOUBLE, bits, 8);
    end
  endfunction

  always @(posedge clk) begin
    cbor_out_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end
    if (rst_n && out_valid) begin
      if (byte_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h last %b", $time,
                 out_data.out_byte, out_data.last);
        fail_count <= fail_count + 1;
      end else begin
        want = byte_q.pop_front();
        if (want.out_byte !== out_data.out_byte || want.last !== out_data.last) begin
          $display("%0t: mismatch, expected %h last %b, actual %h last %b", $time,
                   want.out_byte, want.last, out_data.out_byte, out_data.last);
          fail_count <= fail_count + 1;
        end
      end
    end
    // predict after the compare so a same-cycle byte never meets its own transaction
    if (rst_n && in_start && !in_busy) begin
      if (in_data.command == CMD_FLOAT) encode_float(in_data.value);
      else encode_head(in_data.major_type, in_data.value);
    end
    pending_bytes <= byte_q.size();
  end
endmodule

### tb/tb.sv
// tb: stimulus and verdict for cbor_head_and_float_encoder
// depends on cbor_pkg, the encoder and cbor_checker
module tb;
  import cbor_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_start;
  logic      in_busy;
  cbor_in_t  in_data;
  logic      out_valid;
  cbor_out_t out_data;
  int        fail_count;
  int        pending_bytes;
  int        cycle_count = 0;

  localparam int CYCLE_LIMIT = 200000;

  cbor_head_and_float_encoder dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  cbor_checker chk (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending_bytes(pending_bytes)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog: generous bound over 424 transactions at up to nine bytes each plus gaps
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // hold one transaction until it is accepted; idle gap beforehand unless quiet
  task automatic send(logic cmd, logic [2:0] mt, logic [63:0] val, bit quiet);
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_start <= 1'b0;
        @(posedge clk);
      end
    end
    in_start <= 1'b1;
    in_data <= '{command: cmd, major_type: mt, value: val};
    @(posedge clk);
    while (in_busy) @(posedge clk);
  endtask

  // random double; some cases are built to narrow exactly to half or single
  function automatic logic [63:0] rand_double();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(6))
      0: d[41:0] = '0;                                     // half mantissa
      1: begin d[41:0] = '0; d[62:52] = 11'(1023 + $urandom_range(29) - 14); end
      2: begin d[28:0] = '0; d[62:52] = 11'(1023 + $urandom_range(253) - 126); end
      3: begin d[62:52] = 11'(1023 - 15 - $urandom_range(9));  // half subnormal
         d[51:0] = d[51:0] & ~52'((64'd1 << (13 + $urandom_range(10))) - 1); end
      4: begin d[62:52] = 11'(1023 - 127 - $urandom_range(22)); // single subnormal
         d[51:0] = d[51:0] & ~52'((64'd1 << (29 + $urandom_range(22))) - 1); end
      5: d[62:52] = $urandom_range(1) ? 11'h7ff : 11'h000;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(4))
      0: return 64'($urandom_range(30));
      1: return 64'($urandom_range(255));
      2: return 64'($urandom_range(65535));
      3: return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int n;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: argument size boundaries, all major types, float special cases
    send(CMD_HEAD, 3'd0, 64'd0, 0);
    send(CMD_HEAD, 3'd7, 64'd23, 0);
    send(CMD_HEAD, 3'd1, 64'd24, 0);
    send(CMD_HEAD, 3'd2, 64'hff, 0);
    send(CMD_HEAD, 3'd3, 64'h100, 0);
    send(CMD_HEAD, 3'd4, 64'hffff, 0);
    send(CMD_HEAD, 3'd5, 64'h1_0000, 0);
    send(CMD_HEAD, 3'd6, 64'hffff_ffff, 0);
    send(CMD_HEAD, 3'd7, 64'h1_0000_0000, 0);
    send(CMD_HEAD, 3'd3, '1, 0);
    send(CMD_FLOAT, 3'd5, 64'h0000_0000_0000_0000, 0);  // +0
    send(CMD_FLOAT, 3'd0, 64'h8000_0000_0000_0000, 0);  // -0
    send(CMD_FLOAT, 3'd0, 64'h7ff0_0000_0000_0000, 0);  // +inf
    send(CMD_FLOAT, 3'd0, 64'hfff0_0000_0000_0000, 0);  // -inf
    send(CMD_FLOAT, 3'd0, 64'h7ff8_0000_0000_0001, 0);  // nan
    send(CMD_FLOAT, 3'd0, 64'hffff_ffff_ffff_ffff, 0);  // negative nan
    send(CMD_FLOAT, 3'd0, 64'h0000_0000_0000_0001, 0);  // double subnormal
    send(CMD_FLOAT, 3'd0, 64'h3ff0_0000_0000_0000, 0);  // 1.0 half
    send(CMD_FLOAT, 3'd0, 64'h40ef_fc00_0000_0000, 0);  // 65504 half max
    send(CMD_FLOAT, 3'd0, 64'h3e70_0000_0000_0000, 0);  // smallest half subnormal
    send(CMD_FLOAT, 3'd0, 64'h47ef_ffff_e000_0000, 0);  // single max
    send(CMD_FLOAT, 3'd0, 64'h36a0_0000_0000_0000, 0);  // smallest single subnormal
    send(CMD_FLOAT, 3'd0, 64'h3ff0_0000_0000_0001, 0);  // needs double
    send(CMD_FLOAT, 3'd7, 64'h7fef_ffff_ffff_ffff, 0);  // double max

    // random part; a stretch in the middle runs back to back
    for (n = 0; n < 400; n++) begin
      if ($urandom_range(1)) send(CMD_FLOAT, 3'($urandom), rand_double(), n > 150 && n < 250);
      else send(CMD_HEAD, 3'($urandom), rand_arg(), n > 150 && n < 250);
    end
    in_start <= 1'b0;

    while (pending_bytes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### filelist.f
design/cbor_pkg.sv
design/cbor_front.sv
design/cbor_queue.sv
design/cbor_back.sv
design/cbor_head_and_float_encoder.sv
tb/cbor_checker.sv
tb/tb.sv
